// ===== rtl/wmrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Message rate meter package
// Shared item and result types, operation codes and divider sizing.
// ----------------------------------------------------------------------------
package wmrm_pkg;

  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  // The shared divider is sized for the largest supported window.
  localparam int DIV_NUM_W = 80;
  localparam int DIV_DEN_W = 72;

  localparam logic [47:0] MASK48    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MILLI_NS  = 48'd1000000000000;
  localparam logic [29:0] NS_PER_S  = 30'd1000000000;
  localparam logic [19:0] NS_PER_MS = 20'd1000000;
  localparam logic [9:0]  NS_PER_US = 10'd1000;
  localparam logic [15:0] LIMIT_RESET = 16'd60000;

  // ceil(2^40 / 125): (x >> 3) * LAT_RECIP >> 40 equals x / 1000 for x below 2^36.
  localparam logic [33:0] LAT_RECIP = 34'h2_0C49_BA5F;

  typedef struct packed {
    logic        op;
    logic [63:0] sample_time_ns;
    logic [31:0] sample_bytes;
    logic [63:0] current_time_ns;
  } item_t;

  typedef struct packed {
    logic        stats_available;
    logic [47:0] rate_millihertz;
    logic [39:0] avg_size_q8;
    logic [47:0] bandwidth_bytes_per_sec;
    logic [25:0] latency_us;
  } stats_t;

endpackage

// ===== rtl/wmrm_queue.sv =====
// ----------------------------------------------------------------------------
// Message rate meter input queue
// Two-entry queue that takes input transactions and decodes the operation.
// ----------------------------------------------------------------------------
module wmrm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wmrm_pkg::item_t push_item,
  output logic            full,
  output logic            pop_valid,
  output logic            pop_is_refresh,
  output wmrm_pkg::item_t pop_item,
  input  logic            pop
);

  wmrm_pkg::item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full           = (fill == 2'd2);
  assign pop_valid      = (fill != 2'd0);
  assign pop_item       = entry[rd_ptr];
  assign pop_is_refresh = (entry[rd_ptr].op == wmrm_pkg::OP_REFRESH);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/wmrm_divider.sv =====
// ----------------------------------------------------------------------------
// Message rate meter divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wmrm_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [wmrm_pkg::DIV_NUM_W-1:0] num,
  input  logic [wmrm_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [wmrm_pkg::DIV_NUM_W-1:0] quo
);

  localparam int NW = wmrm_pkg::DIV_NUM_W;
  localparam int DW = wmrm_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] num_sh;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic          fits;

  always_comb begin
    trial    = {rem, num_sh[NW-1]};
    fits     = (trial >= {1'b0, den_r});
    rem_next = fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      den_r  <= den;
      quo    <= '0;
      cnt    <= '0;
    end else if (busy) begin
      rem    <= rem_next;
      num_sh <= {num_sh[NW-2:0], 1'b0};
      quo    <= {quo[NW-2:0], fits};
      cnt    <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/wmrm_engine.sv =====
// ----------------------------------------------------------------------------
// Message rate meter engine
// Holds the record ring and runs push and refresh transactions to completion.
// ----------------------------------------------------------------------------
module wmrm_engine #(
  parameter int WINDOW = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_is_refresh,
  input  wmrm_pkg::item_t   item,
  output logic              item_pop,
  input  logic [15:0]       limit_ms,
  output logic              res_valid,
  input  logic              res_stall,
  output wmrm_pkg::stats_t  res
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int TOT_W = 32 + CNT_W;
  localparam int PT_W  = TOT_W + CNT_W;
  localparam int NW    = wmrm_pkg::DIV_NUM_W;
  localparam int DW    = wmrm_pkg::DIV_DEN_W;
  localparam logic [IDX_W:0]   WIN  = (IDX_W + 1)'(WINDOW);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW - 1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_PUSH_RD  = 11'b000_0000_0010,
    S_PUSH_WR  = 11'b000_0000_0100,
    S_RD_OLD   = 11'b000_0000_1000,
    S_RD_NEW   = 11'b000_0001_0000,
    S_CHECK    = 11'b000_0010_0000,
    S_MUL1     = 11'b000_0100_0000,
    S_MUL2     = 11'b000_1000_0000,
    S_DIV_GO   = 11'b001_0000_0000,
    S_DIV_WAIT = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    DS_RATE, DS_AVG, DS_BW
  } div_sel_t;

  state_t   state;
  div_sel_t sel;

  logic [63:0] time_ring [WINDOW];
  logic [31:0] size_ring [WINDOW];

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [TOT_W-1:0] total;
  logic             have_stats;
  logic [47:0]      rate_reg;
  logic [39:0]      avg_reg;
  logic [47:0]      bw_reg;
  logic [25:0]      lat_reg;

  wmrm_pkg::item_t  cur;
  logic [63:0]      time_rd;
  logic [31:0]      size_rd;
  logic [63:0]      oldest;
  logic [63:0]      span;
  logic [63:0]      diff;
  logic             lat_neg;
  logic             lat_ok;
  logic [35:0]      lim_ns;
  logic [66:0]      lat_prod;
  logic [NW-1:0]    rate_num;
  logic [NW-1:0]    bw_num;
  logic [DW-1:0]    bw_den;
  logic [PT_W-1:0]  nm1_tot;

  logic [IDX_W:0]   old_sum;
  logic [IDX_W-1:0] old_idx;
  logic [IDX_W-1:0] new_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] nm1;

  logic             div_start;
  logic [NW-1:0]    div_num;
  logic [DW-1:0]    div_den;
  logic             div_done;
  logic [NW-1:0]    div_quo;
  logic [47:0]      quo_sat;

  always_comb begin
    old_sum = {1'b0, head} + WIN - (IDX_W + 1)'(count);
    old_idx = (old_sum >= WIN) ? IDX_W'(old_sum - WIN) : old_sum[IDX_W-1:0];
    new_idx = (head == '0) ? LAST : head - IDX_W'(1);
    rd_idx  = (state == S_RD_OLD) ? old_idx : new_idx;
    nm1     = count - CNT_W'(1);
    quo_sat = (|div_quo[NW-1:48]) ? wmrm_pkg::MASK48 : div_quo[47:0];
  end

  always_comb begin
    div_start = (state == S_DIV_GO);
    case (sel)
      DS_RATE: begin
        div_num = rate_num;
        div_den = DW'(span);
      end
      DS_AVG: begin
        div_num = NW'({total, 8'b0});
        div_den = DW'(count);
      end
      default: begin
        div_num = bw_num;
        div_den = bw_den;
      end
    endcase
  end

  wmrm_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Ring storage with one registered read port per array.
  always_ff @(posedge clk) begin
    if (state == S_PUSH_WR) begin
      time_ring[head] <= cur.sample_time_ns;
      size_ring[head] <= cur.sample_bytes;
    end
    time_rd <= time_ring[rd_idx];
    size_rd <= size_ring[head];
  end

  assign item_pop  = (state == S_IDLE) && item_valid;
  assign res_valid = (state == S_EMIT);
  assign res = '{stats_available: have_stats, rate_millihertz: rate_reg,
                 avg_size_q8: avg_reg, bandwidth_bytes_per_sec: bw_reg,
                 latency_us: lat_reg};

  // Datapath working registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur <= item;
      end
      S_RD_OLD: begin
        lim_ns <= 36'(limit_ms) * 36'(wmrm_pkg::NS_PER_MS);
      end
      S_RD_NEW: begin
        oldest <= time_rd;
      end
      S_CHECK: begin
        span    <= time_rd - oldest;
        diff    <= cur.current_time_ns - time_rd;
        lat_neg <= $signed(cur.current_time_ns) < $signed(time_rd);
      end
      S_MUL1: begin
        lat_ok   <= !lat_neg && (diff < 64'(lim_ns));
        // Microseconds by reciprocal multiply; only used when diff is below 2^36.
        lat_prod <= 67'(diff[35:3]) * 67'(wmrm_pkg::LAT_RECIP);
        rate_num <= NW'(48'(nm1) * wmrm_pkg::MILLI_NS);
        bw_den   <= DW'(count) * DW'(span);
        nm1_tot  <= PT_W'(nm1) * PT_W'(total);
      end
      S_MUL2: begin
        bw_num <= NW'(nm1_tot) * NW'(wmrm_pkg::NS_PER_S);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sel        <= DS_RATE;
      head       <= '0;
      count      <= '0;
      total      <= '0;
      have_stats <= 1'b0;
      rate_reg   <= '0;
      avg_reg    <= '0;
      bw_reg     <= '0;
      lat_reg    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (!item_is_refresh) begin
              state <= S_PUSH_RD;
            end else if (count < CNT_W'(2)) begin
              state <= S_EMIT;
            end else begin
              state <= S_RD_OLD;
            end
          end
        end
        S_PUSH_RD: begin
          state <= S_PUSH_WR;
        end
        S_PUSH_WR: begin
          // Once the ring is full the slot being overwritten leaves the total.
          if (count == CNT_W'(WINDOW)) begin
            total <= total - TOT_W'(size_rd) + TOT_W'(cur.sample_bytes);
          end else begin
            total <= total + TOT_W'(cur.sample_bytes);
            count <= count + CNT_W'(1);
          end
          head  <= (head == LAST) ? '0 : head + IDX_W'(1);
          state <= S_EMIT;
        end
        S_RD_OLD: begin
          state <= S_RD_NEW;
        end
        S_RD_NEW: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if ($signed(oldest) < $signed(time_rd)) begin
            have_stats <= 1'b1;
            state      <= S_MUL1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          sel   <= DS_RATE;
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (sel)
              DS_RATE: begin
                rate_reg <= quo_sat;
                sel      <= DS_AVG;
                state    <= S_DIV_GO;
              end
              DS_AVG: begin
                avg_reg <= div_quo[39:0];
                sel     <= DS_BW;
                state   <= S_DIV_GO;
              end
              default: begin
                bw_reg <= quo_sat;
                if (lat_ok) begin
                  lat_reg <= lat_prod[65:40];
                end
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (!res_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/window_message_rate_meter_unit.sv =====
// ----------------------------------------------------------------------------
// Window message rate meter
// Sliding window rate, average size, bandwidth and latency estimator.
// ----------------------------------------------------------------------------
// A push reads the slot to be overwritten, writes the ring and presents its
// result. A refresh that recomputes reads the oldest and newest records,
// then runs three divisions in turn on the bit-serial divider, which
// retires one quotient bit of an 80-bit dividend per cycle; the latency value
// comes from a reciprocal multiply in the same pass. A refresh with fewer than
// two records, or whose span is not positive, skips the arithmetic.
// Throughput: one transaction at a time in the engine; a two-entry input
// queue and the output register let both channels move independently.
// Reset (rst, synchronous, active high) empties the ring, clears all
// statistics and sets the latency limit to 60000 ms. Ring memory is not
// cleared; entries are only read after they have been written.
// ----------------------------------------------------------------------------
module window_message_rate_meter_unit #(
  parameter int WINDOW = 20
) (
  input  logic               clk,
  input  logic               rst,
  // Latency limit register write port.
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [63:0] sample_time_ns,
  input  logic [31:0]        sample_bytes,
  input  logic signed [63:0] current_time_ns,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               stats_available,
  output logic [47:0]        rate_millihertz,
  output logic [39:0]        avg_size_q8,
  output logic [47:0]        bandwidth_bytes_per_sec,
  output logic [25:0]        latency_us
);

  logic             [15:0] limit_ms;
  wmrm_pkg::item_t  in_item;
  logic             q_full;
  logic             q_valid;
  logic             q_is_refresh;
  wmrm_pkg::item_t  q_item;
  logic             q_pop;
  logic             res_valid;
  logic             res_stall;
  wmrm_pkg::stats_t res;
  wmrm_pkg::stats_t out_q;
  logic             out_load;

  // The user must rewrite the limit only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_ms <= wmrm_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_ms <= cfg_data;
    end
  end

  assign in_item = '{op: operation, sample_time_ns: sample_time_ns,
                     sample_bytes: sample_bytes, current_time_ns: current_time_ns};
  assign in_stall = q_full;

  // Front end: buffers incoming transactions and decodes push versus refresh.
  wmrm_queue u_queue (
    .clk            (clk),
    .rst            (rst),
    .push           (in_valid && !q_full),
    .push_item      (in_item),
    .full           (q_full),
    .pop_valid      (q_valid),
    .pop_is_refresh (q_is_refresh),
    .pop_item       (q_item),
    .pop            (q_pop)
  );

  // Back end: ring update and statistics computation.
  wmrm_engine #(
    .WINDOW (WINDOW)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (q_valid),
    .item_is_refresh (q_is_refresh),
    .item            (q_item),
    .item_pop        (q_pop),
    .limit_ms        (limit_ms),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .res             (res)
  );

  // Output register: the engine may hand over a new result whenever the
  // register is empty or its contents are being taken this cycle.
  assign res_stall = out_valid && out_stall;
  assign out_load  = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stats_available         = out_q.stats_available;
  assign rate_millihertz         = out_q.rate_millihertz;
  assign avg_size_q8             = out_q.avg_size_q8;
  assign bandwidth_bytes_per_sec = out_q.bandwidth_bytes_per_sec;
  assign latency_us              = out_q.latency_us;

endmodule
